// ----- design/mpre_pkg.sv -----
// Package for the marker pixel run extractor: constants, pixel class type, classifier.
`default_nettype none

package mpre_pkg;

    localparam int BIT_W          = 5;
    localparam int MASK_W         = 25;
    localparam int GRAY_STEP      = 10;
    localparam int GRAY_FIRST_BIT = 1;
    localparam int GRAY_LAST_BIT  = 24;
    localparam int FIFO_DEPTH     = 4;
    localparam int FIFO_PTR_W     = 2;
    localparam int FIFO_CNT_W     = 3;

    localparam logic [7:0] SAMPLE_MAX  = 8'd255;
    localparam logic [7:0] SAMPLE_ZERO = 8'd0;

    localparam logic [BIT_W-1:0] RED_SYNC_BIT   = 5'd1;
    localparam logic [BIT_W-1:0] GREEN_SYNC_BIT = 5'd2;

    typedef struct packed {
        logic             hit;
        logic [BIT_W-1:0] frame_bit;
        logic             sync;
    } pixel_class_t;

    function automatic pixel_class_t classify(
        input logic [7:0] r,
        input logic [7:0] g,
        input logic [7:0] b
    );
        pixel_class_t c;
        c = '0;
        if (r == g && g == b)
        begin
            for (int k = GRAY_FIRST_BIT; k <= GRAY_LAST_BIT; k++)
            begin
                if (r == 8'(k * GRAY_STEP))
                begin
                    c.hit       = 1'b1;
                    c.frame_bit = BIT_W'(k);
                end
            end
        end
        else if (r == SAMPLE_MAX && g == SAMPLE_ZERO && b == SAMPLE_ZERO)
        begin
            c.hit       = 1'b1;
            c.frame_bit = RED_SYNC_BIT;
            c.sync      = 1'b1;
        end
        else if (r == SAMPLE_ZERO && g == SAMPLE_MAX && b == SAMPLE_ZERO)
        begin
            c.hit       = 1'b1;
            c.frame_bit = GREEN_SYNC_BIT;
            c.sync      = 1'b1;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- design/marker_pixel_run_extractor_top.sv -----
// Top level of the marker pixel run extractor: pixel register, run merge logic, result queue.
`default_nettype none

// Channel  | Dir | Handshake                  | Payload
// s_axis   | in  | s_axis_tvalid/s_axis_tready | tdata: pixel_x, pixel_y, red, green, blue;
//          |     |                            | tlast: end_of_image
// m_axis   | out | m_axis_tvalid/m_axis_tready | tdata: run_x, run_y, run_width, frame_bit,
//          |     |                            | bits_seen; tuser: is_sync; tlast: final_run
//
// One pixel item per cycle while the queue has room; the run merge works on the registered pixel.
// Results leave through a four-entry queue, one item per cycle while m_axis_tready is high.
// A pixel that starts a new run while another run is pending and ends the image gives two results.
// Merge waits while fewer than two queue entries are free; input then stalls.
// rst_n clears the pending run, the seen mask and the queue at once.

module marker_pixel_run_extractor_top
    import mpre_pkg::*;
#(
    parameter int COORD_BITS = 12
)
(
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic                                    s_axis_tvalid,
    output logic                                         s_axis_tready,
    // pixel_x, pixel_y, red, green, blue (lowest first), zero padded to bytes
    input  wire logic [((2*COORD_BITS+24+7)/8)*8-1:0]    s_axis_tdata,
    input  wire logic                                    s_axis_tlast,
    output logic                                         m_axis_tvalid,
    input  wire logic                                    m_axis_tready,
    // run_x, run_y, run_width, frame_bit, bits_seen (lowest first), zero padded
    output logic [((3*COORD_BITS+31+7)/8)*8-1:0]         m_axis_tdata,
    // is_sync
    output logic                                         m_axis_tuser,
    output logic                                         m_axis_tlast
);

    localparam int C       = COORD_BITS;
    localparam int LEN_W   = COORD_BITS + 1;
    localparam int END_W   = COORD_BITS + 2;
    localparam int OUT_RAW = 3 * COORD_BITS + 1 + BIT_W + MASK_W;
    localparam int OUT_W   = ((OUT_RAW + 7) / 8) * 8;
    localparam int ENTRY_W = OUT_RAW + 2;

    logic               pix_valid_reg;
    logic [C-1:0]       pix_x_reg;
    logic [C-1:0]       pix_y_reg;
    logic [7:0]         pix_r_reg;
    logic [7:0]         pix_g_reg;
    logic [7:0]         pix_b_reg;
    logic               pix_eoi_reg;

    logic               run_pending_reg, run_pending_next;
    logic [C-1:0]       run_start_x_reg, run_start_x_next;
    logic [C-1:0]       run_row_reg, run_row_next;
    logic [LEN_W-1:0]   run_length_reg, run_length_next;
    logic [BIT_W-1:0]   run_frame_bit_reg, run_frame_bit_next;
    logic               run_sync_reg, run_sync_next;
    logic [MASK_W-1:0]  seen_mask_reg, seen_mask_next;

    logic [ENTRY_W-1:0]    fifo_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0] fifo_count_reg, fifo_count_next;

    pixel_class_t       pix_class;
    logic               proc_fire;
    logic               pop;
    logic               same_row;
    logic [END_W-1:0]   run_end;
    logic               in_run;
    logic               adjoin;
    logic               start_new;
    logic               grow;
    logic               emit_old;
    logic               flush;
    logic [FIFO_PTR_W-1:0] flush_ptr;
    logic [FIFO_CNT_W-1:0] push_count;

    logic               upd_pending;
    logic [C-1:0]       upd_start_x;
    logic [C-1:0]       upd_row;
    logic [LEN_W-1:0]   upd_length;
    logic [BIT_W-1:0]   upd_frame_bit;
    logic               upd_sync;
    logic [MASK_W-1:0]  upd_mask;

    logic [ENTRY_W-1:0] old_entry;
    logic [ENTRY_W-1:0] flush_entry;
    logic [ENTRY_W-1:0] head_entry;

    assign proc_fire     = pix_valid_reg && (fifo_count_reg <= FIFO_CNT_W'(FIFO_DEPTH - 2));
    assign s_axis_tready = !pix_valid_reg || proc_fire;
    assign pop           = m_axis_tvalid && m_axis_tready;

    assign pix_class = classify(pix_r_reg, pix_g_reg, pix_b_reg);
    assign same_row  = run_pending_reg && (run_row_reg == pix_y_reg);
    assign run_end   = END_W'(run_start_x_reg) + END_W'(run_length_reg);
    assign in_run    = same_row && (pix_x_reg >= run_start_x_reg)
                       && (END_W'(pix_x_reg) < run_end);
    assign adjoin    = same_row && !in_run && (END_W'(pix_x_reg) == run_end)
                       && (run_frame_bit_reg == pix_class.frame_bit)
                       && (run_sync_reg == pix_class.sync);
    assign start_new = pix_class.hit && !in_run && !adjoin;
    assign grow      = pix_class.hit && adjoin;
    assign emit_old  = proc_fire && start_new && run_pending_reg;
    assign flush     = proc_fire && pix_eoi_reg && upd_pending;

    always_comb
    begin
        upd_pending   = run_pending_reg;
        upd_start_x   = run_start_x_reg;
        upd_row       = run_row_reg;
        upd_length    = run_length_reg;
        upd_frame_bit = run_frame_bit_reg;
        upd_sync      = run_sync_reg;
        upd_mask      = seen_mask_reg;
        if (start_new)
        begin
            upd_pending   = 1'b1;
            upd_start_x   = pix_x_reg;
            upd_row       = pix_y_reg;
            upd_length    = LEN_W'(1);
            upd_frame_bit = pix_class.frame_bit;
            upd_sync      = pix_class.sync;
            upd_mask      = seen_mask_reg | (MASK_W'(1) << pix_class.frame_bit);
        end
        else if (grow)
        begin
            upd_length = run_length_reg + LEN_W'(1);
        end
    end

    always_comb
    begin
        run_pending_next   = run_pending_reg;
        run_start_x_next   = run_start_x_reg;
        run_row_next       = run_row_reg;
        run_length_next    = run_length_reg;
        run_frame_bit_next = run_frame_bit_reg;
        run_sync_next      = run_sync_reg;
        seen_mask_next     = seen_mask_reg;
        if (proc_fire)
        begin
            if (pix_eoi_reg)
            begin
                run_pending_next   = 1'b0;
                run_start_x_next   = '0;
                run_row_next       = '0;
                run_length_next    = '0;
                run_frame_bit_next = '0;
                run_sync_next      = 1'b0;
                seen_mask_next     = '0;
            end
            else
            begin
                run_pending_next   = upd_pending;
                run_start_x_next   = upd_start_x;
                run_row_next       = upd_row;
                run_length_next    = upd_length;
                run_frame_bit_next = upd_frame_bit;
                run_sync_next      = upd_sync;
                seen_mask_next     = upd_mask;
            end
        end
    end

    assign old_entry   = {1'b0, run_sync_reg, upd_mask, run_frame_bit_reg, run_length_reg,
                          run_row_reg, run_start_x_reg};
    assign flush_entry = {1'b1, upd_sync, upd_mask, upd_frame_bit, upd_length,
                          upd_row, upd_start_x};

    assign flush_ptr       = wr_ptr_reg + FIFO_PTR_W'(emit_old);
    assign push_count      = FIFO_CNT_W'(emit_old) + FIFO_CNT_W'(flush);
    assign wr_ptr_next     = wr_ptr_reg + FIFO_PTR_W'(push_count);
    assign rd_ptr_next     = rd_ptr_reg + FIFO_PTR_W'(pop);
    assign fifo_count_next = fifo_count_reg + push_count - FIFO_CNT_W'(pop);

    assign head_entry    = fifo_reg[rd_ptr_reg];
    assign m_axis_tvalid = (fifo_count_reg != '0);
    assign m_axis_tdata  = OUT_W'(head_entry[OUT_RAW-1:0]);
    assign m_axis_tuser  = head_entry[OUT_RAW];
    assign m_axis_tlast  = head_entry[OUT_RAW+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_valid_reg     <= 1'b0;
            run_pending_reg   <= 1'b0;
            run_start_x_reg   <= '0;
            run_row_reg       <= '0;
            run_length_reg    <= '0;
            run_frame_bit_reg <= '0;
            run_sync_reg      <= 1'b0;
            seen_mask_reg     <= '0;
            wr_ptr_reg        <= '0;
            rd_ptr_reg        <= '0;
            fifo_count_reg    <= '0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                pix_valid_reg <= s_axis_tvalid;
            end
            run_pending_reg   <= run_pending_next;
            run_start_x_reg   <= run_start_x_next;
            run_row_reg       <= run_row_next;
            run_length_reg    <= run_length_next;
            run_frame_bit_reg <= run_frame_bit_next;
            run_sync_reg      <= run_sync_next;
            seen_mask_reg     <= seen_mask_next;
            wr_ptr_reg        <= wr_ptr_next;
            rd_ptr_reg        <= rd_ptr_next;
            fifo_count_reg    <= fifo_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            pix_x_reg   <= s_axis_tdata[C-1:0];
            pix_y_reg   <= s_axis_tdata[2*C-1:C];
            pix_r_reg   <= s_axis_tdata[2*C+7:2*C];
            pix_g_reg   <= s_axis_tdata[2*C+15:2*C+8];
            pix_b_reg   <= s_axis_tdata[2*C+23:2*C+16];
            pix_eoi_reg <= s_axis_tlast;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_old)
        begin
            fifo_reg[wr_ptr_reg] <= old_entry;
        end
        if (flush)
        begin
            fifo_reg[flush_ptr] <= flush_entry;
        end
    end

    a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_count_reg <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("result queue overflow");

    a_eoi_clears: assert property (@(posedge clk) disable iff (!rst_n)
        proc_fire && pix_eoi_reg |=> !run_pending_reg && (seen_mask_reg == '0))
        else $error("state not cleared after end of image");

    a_pending_len: assert property (@(posedge clk) disable iff (!rst_n)
        run_pending_reg |-> (run_length_reg != '0) && (run_frame_bit_reg != '0))
        else $error("pending run with empty length or bit");

    a_mask_low: assert property (@(posedge clk) disable iff (!rst_n)
        !seen_mask_reg[0])
        else $error("seen mask bit zero set");

    a_two_results: assert property (@(posedge clk) disable iff (!rst_n)
        emit_old && flush |-> pix_eoi_reg && start_new)
        else $error("double result without new run at end of image");

endmodule

`default_nettype wire
